[rtl/wdm_pkg.sv]
// ----------------------------------------------------------------------------
// Wildcard dictionary matcher package
// Shared constants, command codes and the slot type that runs down the cells.
// ----------------------------------------------------------------------------
package wdm_pkg;

    localparam int MAX_WORDS = 1024;
    localparam int MAX_LEN   = 16;
    localparam int IDX_W     = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int LEN_W     = $clog2(MAX_LEN + 2);
    localparam int PIDX_W    = $clog2(MAX_LEN);
    localparam int CHARS_W   = MAX_LEN * 8;
    localparam int ROW_W     = CHARS_W + LEN_W;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_COUNT = 2'd1;
    localparam logic [1:0] CMD_FIND  = 2'd2;
    localparam logic [1:0] CMD_EXACT = 2'd3;

    localparam logic [7:0] WILDCARD = 8'd32;

    typedef struct packed {
        logic             valid;
        logic             tail;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_slot;

endpackage

[rtl/wdm_if.sv]
// ----------------------------------------------------------------------------
// Wildcard dictionary matcher channels
// Valid/ready interfaces for the input word and the result word.
// ----------------------------------------------------------------------------
interface wdm_in_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              command;
    logic [7:0]              char_code;
    logic                    last;
    logic [10:0]             limit;
    logic [wdm_pkg::IDX_W-1:0] start_index;

    modport source (output valid, command, char_code, last, limit, start_index,
                    input ready);
    modport sink (input valid, command, char_code, last, limit, start_index,
                  output ready);
endinterface

interface wdm_out_if;
    logic                    valid;
    logic                    ready;
    logic                    status;
    logic [wdm_pkg::CNT_W-1:0] match_count;
    logic                    found;
    logic [wdm_pkg::IDX_W-1:0] word_index;

    modport source (output valid, status, match_count, found, word_index,
                    input ready);
    modport sink (input valid, status, match_count, found, word_index,
                  output ready);
endinterface

[rtl/wdm_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/wdm_cell.sv]
// ----------------------------------------------------------------------------
// Compare cell
// Checks the lowest character of a passing word against its pattern character
// and hands the slot and the remaining characters on to the next cell.
// ----------------------------------------------------------------------------
module wdm_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  wdm_pkg::t_slot          i_slot,
    input  logic [wdm_pkg::CHARS_W-1:0] i_chars,
    input  logic [7:0]              i_pat_char,
    input  logic                    i_pat_en,
    input  logic                    i_wild,
    output wdm_pkg::t_slot          o_slot,
    output logic [wdm_pkg::CHARS_W-1:0] o_chars
);

    logic           w_char_ok;
    wdm_pkg::t_slot n_slot;

    assign w_char_ok = !i_pat_en || (i_chars[7:0] == i_pat_char)
                       || (i_wild && (i_pat_char == wdm_pkg::WILDCARD));

    always_comb begin
        n_slot     = i_slot;
        n_slot.hit = i_slot.hit && w_char_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_slot.valid <= 1'b0;
        end else begin
            o_slot.valid <= n_slot.valid;
        end
        o_slot.tail <= n_slot.tail;
        o_slot.hit  <= n_slot.hit;
        o_slot.idx  <= n_slot.idx;
        o_chars     <= {8'd0, i_chars[wdm_pkg::CHARS_W-1:8]};
    end

endmodule

[rtl/wildcard_dictionary_matcher_core.sv]
// ----------------------------------------------------------------------------
// Wildcard dictionary matcher
// Stores words and answers count, find-next and exact lookup queries.
// ----------------------------------------------------------------------------
// Input words on i_in carry one character each with a command; a word or
// pattern ends on a word with last set. Each last character yields exactly
// one result word on o_out; other characters yield none.
// The result of a load is registered and appears in the cycle after its
// last character. A query ends with a scan: stored rows are read from the
// word RAM one per cycle, at least one row, from start_index for find-next
// and from row zero otherwise, up to the word count, and each row passes
// down a chain of MAX_LEN compare cells, one character per cell. The scan
// rate is set by the single read port of the RAM.
// No input word is taken during a scan or while a result waits and the
// receiver stalls; a result is held until o_out.ready is seen.
// Reset empties the dictionary and clears the partial word and pattern;
// no clearing pass is needed, rows beyond the word count are never compared.
// ----------------------------------------------------------------------------
module wildcard_dictionary_matcher_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wdm_in_if.sink    i_in,
    wdm_out_if.source o_out
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]                   r_state;
    logic [wdm_pkg::CNT_W-1:0]    r_stored;
    logic [wdm_pkg::LEN_W-1:0]    r_ld_pos;
    logic                         r_ld_ovf;
    logic [wdm_pkg::CHARS_W-1:0]  r_ld_buf;
    logic [wdm_pkg::LEN_W-1:0]    r_plen;
    logic [7:0]                   r_pat [wdm_pkg::MAX_LEN];
    logic [wdm_pkg::LEN_W-1:0]    r_qlen;
    logic [1:0]                   r_qmode;
    logic [10:0]                  r_limit;
    logic [wdm_pkg::CNT_W-1:0]    r_w;
    logic                         r_iss_v;
    logic                         r_iss_ok;
    logic                         r_iss_tail;
    logic [wdm_pkg::IDX_W-1:0]    r_iss_idx;
    logic [wdm_pkg::CNT_W-1:0]    r_cnt;
    logic                         r_found;
    logic [wdm_pkg::IDX_W-1:0]    r_fidx;
    logic                         r_out_valid;
    logic                         r_out_status;
    logic [wdm_pkg::CNT_W-1:0]    r_out_count;
    logic                         r_out_found;
    logic [wdm_pkg::IDX_W-1:0]    r_out_idx;

    logic                         w_accept;
    logic                         w_is_load;
    logic                         w_pos_ok;
    logic                         w_discard;
    logic                         w_we;
    logic [wdm_pkg::CHARS_W-1:0]  w_ld_chars;
    logic [wdm_pkg::LEN_W-1:0]    n_ld_pos;
    logic [wdm_pkg::LEN_W-1:0]    n_plen;
    logic [wdm_pkg::ROW_W-1:0]    w_rdata;
    logic                         w_tail;
    logic                         w_slot_ok;
    wdm_pkg::t_slot               w_slot [wdm_pkg::MAX_LEN+1];
    logic [wdm_pkg::CHARS_W-1:0]  w_chars [wdm_pkg::MAX_LEN+1];
    logic                         w_wild;
    wdm_pkg::t_slot               w_end;
    logic [wdm_pkg::CNT_W-1:0]    n_cnt;
    logic                         n_found;
    logic [wdm_pkg::IDX_W-1:0]    n_fidx;
    logic                         w_taken;

    assign w_taken   = o_out.valid && o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept  = i_in.valid && i_in.ready;
    assign w_is_load = (i_in.command == wdm_pkg::CMD_LOAD);

    assign w_pos_ok  = (r_ld_pos < wdm_pkg::LEN_W'(wdm_pkg::MAX_LEN));
    assign n_ld_pos  = w_pos_ok ? r_ld_pos + 1'b1 : r_ld_pos;
    assign w_discard = r_ld_ovf || !w_pos_ok
                       || (r_stored >= wdm_pkg::CNT_W'(wdm_pkg::MAX_WORDS));
    assign w_we      = w_accept && w_is_load && i_in.last && !w_discard;
    assign n_plen    = (r_plen <= wdm_pkg::LEN_W'(wdm_pkg::MAX_LEN))
                       ? r_plen + 1'b1 : r_plen;

    always_comb begin
        w_ld_chars = r_ld_buf;
        if (w_pos_ok) begin
            w_ld_chars[r_ld_pos[wdm_pkg::PIDX_W-1:0]*8 +: 8] = i_in.char_code;
        end
    end

    wdm_ram #(
        .WIDTH (wdm_pkg::ROW_W),
        .DEPTH (wdm_pkg::MAX_WORDS)
    ) u_words (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_stored[wdm_pkg::IDX_W-1:0]),
        .i_wdata ({n_ld_pos, w_ld_chars}),
        .i_raddr (r_w[wdm_pkg::IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_tail = ({1'b0, r_w} + 1'b1) >= {1'b0, r_stored};
    assign w_wild = (r_qmode != wdm_pkg::CMD_EXACT);

    always_comb begin
        w_slot[0].valid = r_iss_v;
        w_slot[0].tail  = r_iss_tail;
        w_slot[0].hit   = r_iss_ok
                          && (w_rdata[wdm_pkg::ROW_W-1 -: wdm_pkg::LEN_W] == r_qlen)
                          && (r_qlen <= wdm_pkg::LEN_W'(wdm_pkg::MAX_LEN));
        w_slot[0].idx   = r_iss_idx;
        w_chars[0]      = w_rdata[wdm_pkg::CHARS_W-1:0];
    end

    for (genvar g = 0; g < wdm_pkg::MAX_LEN; g++) begin : g_cell
        wdm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_slot     (w_slot[g]),
            .i_chars    (w_chars[g]),
            .i_pat_char (r_pat[g]),
            .i_pat_en   (wdm_pkg::LEN_W'(g) < r_qlen),
            .i_wild     (w_wild),
            .o_slot     (w_slot[g+1]),
            .o_chars    (w_chars[g+1])
        );
    end

    assign w_end     = w_slot[wdm_pkg::MAX_LEN];
    assign w_slot_ok = r_w < r_stored;

    always_comb begin
        n_cnt   = r_cnt;
        n_found = r_found;
        n_fidx  = r_fidx;
        if (w_end.valid && w_end.hit) begin
            if (11'(r_cnt) < r_limit) begin
                n_cnt = r_cnt + 1'b1;
            end
            if (!r_found) begin
                n_found = 1'b1;
                n_fidx  = w_end.idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_stored    <= '0;
            r_ld_pos    <= '0;
            r_ld_ovf    <= 1'b0;
            r_plen      <= '0;
            r_iss_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_iss_v <= (r_state == ST_SCAN);
            if (w_accept && w_is_load) begin
                if (i_in.last) begin
                    r_ld_pos <= '0;
                    r_ld_ovf <= 1'b0;
                    if (w_we) begin
                        r_stored <= r_stored + 1'b1;
                    end
                end else begin
                    r_ld_pos <= n_ld_pos;
                    r_ld_ovf <= r_ld_ovf || !w_pos_ok;
                end
            end
            if (w_accept && !w_is_load) begin
                if (i_in.last) begin
                    r_plen  <= '0;
                    r_state <= ST_SCAN;
                end else begin
                    r_plen <= n_plen;
                end
            end
            if (w_accept && w_is_load && i_in.last) begin
                r_out_valid <= 1'b1;
            end else if ((r_state == ST_DRAIN) && w_end.valid && w_end.tail) begin
                r_out_valid <= 1'b1;
            end else if (w_taken) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_SCAN: begin
                    if (w_tail) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_end.valid && w_end.tail) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_load && w_pos_ok) begin
            r_ld_buf <= w_ld_chars;
        end
        if (w_accept && !w_is_load && (r_plen < wdm_pkg::LEN_W'(wdm_pkg::MAX_LEN))) begin
            r_pat[r_plen[wdm_pkg::PIDX_W-1:0]] <= i_in.char_code;
        end
        r_iss_ok   <= w_slot_ok;
        r_iss_tail <= w_tail;
        r_iss_idx  <= r_w[wdm_pkg::IDX_W-1:0];
        if (r_state == ST_SCAN) begin
            r_w <= r_w + 1'b1;
        end
        if (r_state != ST_IDLE) begin
            r_cnt   <= n_cnt;
            r_found <= n_found;
            r_fidx  <= n_fidx;
        end
        if (w_accept && !w_is_load && i_in.last) begin
            r_qlen  <= n_plen;
            r_qmode <= i_in.command;
            r_limit <= i_in.limit;
            r_w     <= (i_in.command == wdm_pkg::CMD_FIND)
                       ? {1'b0, i_in.start_index} : '0;
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_fidx  <= '0;
        end
        if (w_accept && w_is_load && i_in.last) begin
            r_out_status <= w_discard;
            r_out_count  <= '0;
            r_out_found  <= 1'b0;
            r_out_idx    <= '0;
        end
        if ((r_state == ST_DRAIN) && w_end.valid && w_end.tail) begin
            r_out_status <= 1'b0;
            r_out_count  <= (r_qmode == wdm_pkg::CMD_COUNT) ? n_cnt : '0;
            r_out_found  <= (r_qmode != wdm_pkg::CMD_COUNT) && n_found;
            r_out_idx    <= (r_qmode == wdm_pkg::CMD_FIND) ? n_fidx : '0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.match_count = r_out_count;
    assign o_out.found       = r_out_found;
    assign o_out.word_index  = r_out_idx;

    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= wdm_pkg::CNT_W'(wdm_pkg::MAX_WORDS))
        else $error("word count beyond store size");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_in.ready)
        else $error("input taken during a scan");

    a_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (r_qmode == wdm_pkg::CMD_COUNT) && !o_out.status)
        |-> (11'(o_out.match_count) <= r_limit))
        else $error("match count above limit");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DRAIN) && w_end.valid && w_end.tail) |=> o_out.valid)
        else $error("scan finished without a result");

endmodule

[dv/wdm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard dictionary matcher result checker
// Watches both channels, keeps its own copy of the dictionary and pattern,
// predicts one result per last character and compares it field by field.
// ----------------------------------------------------------------------------
module wdm_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wdm_in_if         i_in,
    wdm_out_if        i_out,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic                      status;
        logic [wdm_pkg::CNT_W-1:0] match_count;
        logic                      found;
        logic [wdm_pkg::IDX_W-1:0] word_index;
    } t_answer;

    logic [7:0] dict_text [wdm_pkg::MAX_WORDS][wdm_pkg::MAX_LEN];
    int         dict_len  [wdm_pkg::MAX_WORDS];
    int         dict_size;
    logic [7:0] pat_text  [wdm_pkg::MAX_LEN];
    int         pat_len;
    int         load_pos;
    logic       load_long;
    t_answer    answer_q[$];

    function automatic logic word_fits(int w, logic wild);
        if (pat_len > wdm_pkg::MAX_LEN || dict_len[w] != pat_len) return 1'b0;
        for (int i = 0; i < pat_len; i++)
            if (dict_text[w][i] != pat_text[i]
                && !(wild && pat_text[i] == wdm_pkg::WILDCARD))
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic absorb_char(logic [1:0] cmd, logic [7:0] ch, logic lst,
                               int lim, int start);
        t_answer a;
        a = '0;
        if (cmd == wdm_pkg::CMD_LOAD) begin
            if (load_pos < wdm_pkg::MAX_LEN) begin
                if (dict_size < wdm_pkg::MAX_WORDS) dict_text[dict_size][load_pos] = ch;
                load_pos++;
            end else begin
                load_long = 1'b1;
            end
            if (!lst) return;
            if (load_long || dict_size >= wdm_pkg::MAX_WORDS) begin
                a.status = 1'b1;
            end else begin
                dict_len[dict_size] = load_pos;
                dict_size++;
            end
            load_pos  = 0;
            load_long = 1'b0;
        end else begin
            if (pat_len < wdm_pkg::MAX_LEN) pat_text[pat_len] = ch;
            if (pat_len <= wdm_pkg::MAX_LEN) pat_len++;
            if (!lst) return;
            if (cmd == wdm_pkg::CMD_COUNT) begin
                for (int w = 0; w < dict_size && a.match_count < lim; w++)
                    if (word_fits(w, 1'b1)) a.match_count++;
            end else if (cmd == wdm_pkg::CMD_FIND) begin
                for (int w = start; w < dict_size; w++)
                    if (word_fits(w, 1'b1)) begin
                        a.found = 1'b1;
                        a.word_index = wdm_pkg::IDX_W'(w);
                        break;
                    end
            end else begin
                for (int w = 0; w < dict_size; w++)
                    if (word_fits(w, 1'b0)) begin
                        a.found = 1'b1;
                        break;
                    end
            end
            pat_len = 0;
        end
        answer_q = {answer_q, a};
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            dict_size    = 0;
            pat_len      = 0;
            load_pos     = 0;
            load_long    = 1'b0;
            o_fail_count = 0;
            answer_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.status, i_out.match_count, i_out.found, i_out.word_index};
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result word %p", $time, got);
                    o_fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (got.status !== want.status || got.match_count !== want.match_count
                        || got.found !== want.found || got.word_index !== want.word_index) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        o_fail_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                absorb_char(i_in.command, i_in.char_code, i_in.last,
                            i_in.limit, i_in.start_index);
        end
        o_pending = answer_q.size();
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard dictionary matcher testbench
// Loads words from a small alphabet, runs directed corner cases and then
// random word loads and count, find-next and exact queries with bursty
// input and a stalling receiver; the checker predicts every result.
// ----------------------------------------------------------------------------
module tb;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    int   burst_left;
    int   gap_left;
    int   stall_phase = 0;
    int   words_in;

    wdm_in_if  in_ch ();
    wdm_out_if out_ch ();

    wildcard_dictionary_matcher_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    wdm_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 97 < 40) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] pick_char(int mode);
        case (mode)
            0: return 8'd97 + 8'($urandom_range(0, 2));
            1: return wdm_pkg::WILDCARD;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_char(logic [1:0] cmd, logic [7:0] ch, logic lst,
                             logic [10:0] lim, logic [wdm_pkg::IDX_W-1:0] start);
        if (burst_left == 0) begin
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap_left > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap_left) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.char_code   <= ch;
        in_ch.last        <= lst;
        in_ch.limit       <= lim;
        in_ch.start_index <= start;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_in++;
    endtask

    task automatic send_string(logic [1:0] cmd, int len, int mode,
                               logic [10:0] lim, logic [wdm_pkg::IDX_W-1:0] start);
        for (int i = 0; i < len; i++) begin
            int m;
            m = (mode == 1 && $urandom_range(0, 2) != 0) ? 0 : mode;
            send_char(cmd, pick_char(m), i == len - 1, lim, start);
        end
    endtask

    initial begin
        int len;
        int kind;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = wdm_pkg::CMD_LOAD;
        in_ch.char_code = '0;
        in_ch.last = 1'b0;
        in_ch.limit = '0;
        in_ch.start_index = '0;
        burst_left = 0;
        words_in = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_string(wdm_pkg::CMD_COUNT, 2, 0, 11'd5, '0);
        send_char(wdm_pkg::CMD_LOAD, 8'd0, 1'b0, '0, '0);
        send_char(wdm_pkg::CMD_LOAD, 8'd255, 1'b1, '0, '0);
        send_char(wdm_pkg::CMD_LOAD, 8'd32, 1'b0, '0, '0);
        send_char(wdm_pkg::CMD_FIND, 8'd0, 1'b0, '0, '0);
        send_char(wdm_pkg::CMD_LOAD, 8'd97, 1'b1, '0, '0);
        send_char(wdm_pkg::CMD_COUNT, 8'd32, 1'b0, '0, '0);
        send_char(wdm_pkg::CMD_FIND, 8'd32, 1'b1, '0, 10'd1);
        send_char(wdm_pkg::CMD_EXACT, 8'd32, 1'b0, '0, '0);
        send_char(wdm_pkg::CMD_EXACT, 8'd97, 1'b1, '0, '0);
        send_char(wdm_pkg::CMD_COUNT, 8'd32, 1'b0, '0, '0);
        send_char(wdm_pkg::CMD_COUNT, 8'd32, 1'b1, 11'd1024, '0);
        send_char(wdm_pkg::CMD_COUNT, 8'd32, 1'b0, '0, '0);
        send_char(wdm_pkg::CMD_COUNT, 8'd32, 1'b1, 11'd0, '0);
        send_string(wdm_pkg::CMD_LOAD, wdm_pkg::MAX_LEN, 2, '0, '0);
        send_string(wdm_pkg::CMD_LOAD, wdm_pkg::MAX_LEN + 3, 2, '0, '0);
        send_string(wdm_pkg::CMD_FIND, wdm_pkg::MAX_LEN + 2, 1, '0, 10'd1023);
        send_string(wdm_pkg::CMD_EXACT, wdm_pkg::MAX_LEN, 2, 11'd2047, '0);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);

        while (words_in < 700) begin
            kind = $urandom_range(0, 9);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, wdm_pkg::MAX_LEN + 3)
                                               : $urandom_range(1, 3);
            if (kind < 5)
                send_string(wdm_pkg::CMD_LOAD, len, $urandom_range(0, 7) == 0 ? 2 : 0,
                            '0, '0);
            else
                send_string(2'($urandom_range(1, 3)), len,
                            $urandom_range(0, 7) == 0 ? 2 : 1,
                            11'($urandom_range(0, 2047)),
                            wdm_pkg::IDX_W'($urandom_range(0, 1023)));
        end
        send_string(wdm_pkg::CMD_FIND, 1, 1, '0, 10'd1023);
        send_string(wdm_pkg::CMD_COUNT, 1, 1, 11'd1024, '0);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);

        wait (pending == 0);
        repeat (wdm_pkg::MAX_WORDS + wdm_pkg::MAX_LEN + 20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
